### hdl/bmhpq_pkg.sv
// ----------------------------------------------------------------------------
// bmhpq_pkg
// Shared constants and types of the binary max-heap priority queue.
// ----------------------------------------------------------------------------
package bmhpq_pkg;

  // default number of heap slots
  localparam int unsigned CAPACITY_DEF = 64;

  // fixed field widths
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned STAT_W  = 2;

  // operation codes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  // verdict of the shared compare unit
  typedef struct packed {
    logic moved;   // a candidate beats the base key
    logic pick_b;  // the winner is candidate b
  } sift_res_t;

endpackage : bmhpq_pkg

### hdl/bmhpq_store.sv
// ----------------------------------------------------------------------------
// bmhpq_store
// Heap slot memory: one write port, two read ports with registered data.
// ----------------------------------------------------------------------------
module bmhpq_store #(
  parameter int unsigned DEPTH = bmhpq_pkg::CAPACITY_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AW-1:0]              waddr_i,
  input  logic [bmhpq_pkg::KEY_W-1:0] wdata_i,
  input  logic [AW-1:0]              raddr_a_i,
  input  logic [AW-1:0]              raddr_b_i,
  output logic [bmhpq_pkg::KEY_W-1:0] rdata_a_o,
  output logic [bmhpq_pkg::KEY_W-1:0] rdata_b_o
);
  import bmhpq_pkg::*;

  logic [KEY_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read ports
  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule : bmhpq_store

### hdl/bmhpq_sift.sv
// ----------------------------------------------------------------------------
// bmhpq_sift
// Shared signed compare unit: does candidate a or b beat the base key.
// ----------------------------------------------------------------------------
module bmhpq_sift (
  input  logic [bmhpq_pkg::KEY_W-1:0] base_key_i,
  input  logic [bmhpq_pkg::KEY_W-1:0] cand_a_i,
  input  logic [bmhpq_pkg::KEY_W-1:0] cand_b_i,
  input  logic                        b_ok_i,
  output bmhpq_pkg::sift_res_t        res_o
);
  import bmhpq_pkg::*;

  logic             a_gt;
  logic             b_gt;
  logic [KEY_W-1:0] best_a;

  // a wins only when strictly larger, then b must beat the better of the two
  always_comb begin
    a_gt         = $signed(cand_a_i) > $signed(base_key_i);
    best_a       = a_gt ? cand_a_i : base_key_i;
    b_gt         = b_ok_i && ($signed(cand_b_i) > $signed(best_a));
    res_o.moved  = a_gt || b_gt;
    res_o.pick_b = b_gt;
  end

endmodule : bmhpq_sift

### hdl/binary_max_heap_priority_queue.sv
// ----------------------------------------------------------------------------
// binary_max_heap_priority_queue
// Max-priority queue of signed keys held as an implicit binary heap.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid_i / in_ready_o) carries one item: operation_i
//   (0 push key_i, 1 pop the largest entry). Output channel (out_valid_o /
//   out_ready_i) returns one result per item: top_key_o, count_o,
//   is_empty_o and status_o (0 ok, 1 pop on empty, 2 push on full).
//   One item is processed at a time by a sequencer that drives the slot
//   memory and a single signed compare unit.
//   A push climbs from the new last slot until it reaches the root or
//   stops below it. A pop fetches the last entry, takes it to the root
//   and sinks it until it ends on a leaf or stops above one. Error cases
//   load their result when the item is accepted, with no memory access.
//   Each heap level takes a memory read state and a compare/write state
//   on the shared read/compare path. The queue takes no new item until
//   it is through with the last one.
//   The result sits in an output register; a new item is taken once that
//   register is empty or being drained in the same cycle, so a stalled
//   receiver holds the queue after one pending result.
//   Reset clears the entry count and the control state; slot contents
//   need no clearing since data read from unoccupied slots is never used.
// ----------------------------------------------------------------------------
module binary_max_heap_priority_queue #(
  parameter int unsigned CAPACITY = bmhpq_pkg::CAPACITY_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          operation_i,
  input  logic signed [bmhpq_pkg::KEY_W-1:0] key_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [bmhpq_pkg::KEY_W-1:0] top_key_o,
  output logic [bmhpq_pkg::COUNT_W-1:0] count_o,
  output logic                          is_empty_o,
  output logic [bmhpq_pkg::STAT_W-1:0]  status_o
);
  import bmhpq_pkg::*;

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned LW = IW + 2;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_UP_RD  = 7'b0000010,
    S_UP_CMP = 7'b0000100,
    S_POP_RD = 7'b0001000,
    S_POP_LD = 7'b0010000,
    S_DN_RD  = 7'b0100000,
    S_DN_CMP = 7'b1000000
  } state_e;

  state_e            state_q, state_d;
  logic [IW-1:0]     pos_q, pos_d;
  logic [KEY_W-1:0]  v_q, v_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [KEY_W-1:0]  top_q;

  logic              out_valid_q;
  logic [KEY_W-1:0]  out_top_q, out_top_d;
  logic [CW-1:0]     out_cnt_q;
  logic [STAT_W-1:0] out_stat_q, out_stat_d;
  logic              load_out;

  logic              we;
  logic [IW-1:0]     waddr;
  logic [KEY_W-1:0]  wdata;
  logic [IW-1:0]     raddr_a, raddr_b;
  logic [KEY_W-1:0]  rdata_a, rdata_b;

  logic [KEY_W-1:0]  base_key, cand_a, cand_b;
  logic              b_ok;
  sift_res_t         sres;

  logic              accept;
  logic              full;
  logic [CW-1:0]     cnt_m1;
  logic [IW-1:0]     pos_m1, parent;
  logic [LW-1:0]     l_w, r_w, n_w;
  logic [KEY_W-1:0]  top_now;
  logic [CW+COUNT_W-1:0] cnt_wide;

  // slot memory
  bmhpq_store #(
    .DEPTH (CAPACITY),
    .AW    (IW)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  // shared compare unit
  bmhpq_sift u_sift (
    .base_key_i (base_key),
    .cand_a_i   (cand_a),
    .cand_b_i   (cand_b),
    .b_ok_i     (b_ok),
    .res_o      (sres)
  );

  // index arithmetic
  always_comb begin
    full   = (cnt_q == CW'(CAPACITY));
    cnt_m1 = cnt_q - 1'b1;
    pos_m1 = pos_q - 1'b1;
    parent = pos_m1 >> 1;
    l_w    = {1'b0, pos_q, 1'b1};
    r_w    = l_w + 1'b1;
    n_w    = LW'(cnt_q);
  end

  // compare unit operands: sift-up checks the key against its parent,
  // sift-down checks both children against the moving key
  always_comb begin
    if (state_q == S_UP_CMP) begin
      base_key = rdata_a;
      cand_a   = v_q;
      cand_b   = v_q;
      b_ok     = 1'b0;
    end else begin
      base_key = v_q;
      cand_a   = rdata_a;
      cand_b   = rdata_b;
      b_ok     = (r_w < n_w);
    end
  end

  // a new item is taken only when idle and the result register can take it
  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  // sequencer
  always_comb begin
    state_d    = state_q;
    pos_d      = pos_q;
    v_d        = v_q;
    cnt_d      = cnt_q;
    we         = 1'b0;
    waddr      = pos_q;
    wdata      = v_q;
    raddr_a    = pos_q;
    raddr_b    = pos_q;
    load_out   = 1'b0;
    out_stat_d = STAT_OK;
    out_top_d  = top_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (operation_i == OP_PUSH) begin
            if (full) begin
              load_out   = 1'b1;
              out_stat_d = STAT_FULL;
            end else begin
              pos_d   = cnt_q[IW-1:0];
              v_d     = key_i;
              cnt_d   = cnt_q + 1'b1;
              state_d = S_UP_RD;
            end
          end else begin
            if (cnt_q == '0) begin
              load_out   = 1'b1;
              out_stat_d = STAT_EMPTY;
              out_top_d  = '0;
            end else begin
              cnt_d   = cnt_m1;
              pos_d   = cnt_m1[IW-1:0];
              state_d = S_POP_RD;
            end
          end
        end
      end

      // fetch the parent, or settle at the root
      S_UP_RD: begin
        if (pos_q == '0) begin
          we       = 1'b1;
          load_out = 1'b1;
          state_d  = S_IDLE;
        end else begin
          raddr_a = parent;
          state_d = S_UP_CMP;
        end
      end

      // move a smaller parent down, or settle the key here
      S_UP_CMP: begin
        we = 1'b1;
        if (sres.moved) begin
          wdata   = rdata_a;
          pos_d   = parent;
          state_d = S_UP_RD;
        end else begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end

      // fetch the last entry
      S_POP_RD: begin
        raddr_a = pos_q;
        state_d = S_POP_LD;
      end

      S_POP_LD: begin
        v_d     = rdata_a;
        pos_d   = '0;
        state_d = S_DN_RD;
      end

      // fetch both children, or settle when there is none
      S_DN_RD: begin
        if (l_w < n_w) begin
          raddr_a = l_w[IW-1:0];
          raddr_b = r_w[IW-1:0];
          state_d = S_DN_CMP;
        end else begin
          we       = 1'b1;
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end

      // lift the larger child, or settle the key here
      S_DN_CMP: begin
        we = 1'b1;
        if (sres.moved) begin
          wdata   = sres.pick_b ? rdata_b : rdata_a;
          pos_d   = sres.pick_b ? r_w[IW-1:0] : l_w[IW-1:0];
          state_d = S_DN_RD;
        end else begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // completed operations report the root as it stands after the write
    top_now = (we && (waddr == '0)) ? wdata : top_q;
    if (load_out && (state_q != S_IDLE)) begin
      out_top_d = (cnt_q == '0) ? '0 : top_now;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    v_q   <= v_d;
    if (we && (waddr == '0)) begin
      top_q <= wdata;
    end
    if (load_out) begin
      out_top_q  <= out_top_d;
      out_cnt_q  <= cnt_d;
      out_stat_q <= out_stat_d;
    end
  end

  // result outputs
  assign cnt_wide    = {{COUNT_W{1'b0}}, out_cnt_q};
  assign out_valid_o = out_valid_q;
  assign top_key_o   = out_top_q;
  assign count_o     = cnt_wide[COUNT_W-1:0];
  assign is_empty_o  = (out_cnt_q == '0);
  assign status_o    = out_stat_q;

endmodule : binary_max_heap_priority_queue

### hdl/bmhpq_checker.sv
// ----------------------------------------------------------------------------
// bmhpq_checker
// Port-level checks of the priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module bmhpq_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [bmhpq_pkg::KEY_W-1:0]   top_key_o,
  input logic [bmhpq_pkg::COUNT_W-1:0] count_o,
  input logic                          is_empty_o,
  input logic [bmhpq_pkg::STAT_W-1:0]  status_o
);
  import bmhpq_pkg::*;

  // empty flag agrees with the count
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (is_empty_o == (count_o == '0)))
    else $error("is_empty disagrees with count");

  // an empty queue reports a zero top key
  a_empty_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_empty_o) |-> (top_key_o == '0))
    else $error("empty queue reports nonzero top key");

  // a pop on empty leaves the queue empty
  a_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == STAT_EMPTY)) |-> is_empty_o)
    else $error("pop-on-empty status with entries held");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(top_key_o) && $stable(count_o) && $stable(status_o)))
    else $error("stalled result changed");

endmodule : bmhpq_checker

bind binary_max_heap_priority_queue bmhpq_checker u_bmhpq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .top_key_o   (top_key_o),
  .count_o     (count_o),
  .is_empty_o  (is_empty_o),
  .status_o    (status_o)
);

### test/binary_max_heap_priority_queue_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_max_heap_priority_queue_checker
// Watches both channels of the heap queue, keeps its own copy of the heap,
// and compares every returned result against the predicted one.
// ----------------------------------------------------------------------------
module binary_max_heap_priority_queue_checker #(
  parameter int unsigned CAPACITY = bmhpq_pkg::CAPACITY_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic                               in_ready_i,
  input  logic                               operation_i,
  input  logic signed [bmhpq_pkg::KEY_W-1:0] key_i,
  input  logic                               out_valid_i,
  input  logic                               out_ready_i,
  input  logic signed [bmhpq_pkg::KEY_W-1:0] top_key_i,
  input  logic [bmhpq_pkg::COUNT_W-1:0]      count_i,
  input  logic                               is_empty_i,
  input  logic [bmhpq_pkg::STAT_W-1:0]       status_i,
  output int                                 err_cnt_o,
  output int                                 pending_o
);
  import bmhpq_pkg::*;

  // one predicted result item
  typedef struct packed {
    logic signed [KEY_W-1:0] top_key;
    logic [COUNT_W-1:0]      count;
    logic                    is_empty;
    logic [STAT_W-1:0]       status;
  } heap_result_t;

  // shadow heap
  logic signed [KEY_W-1:0] heap_slots [CAPACITY];
  int unsigned             n_held;

  heap_result_t            result_q [$];
  heap_result_t            want;
  heap_result_t            predicted;
  int                      errs;

  // apply one operation to the shadow heap and return the expected result
  function automatic heap_result_t apply_heap_op(input logic op,
                                                 input logic signed [KEY_W-1:0] k);
    heap_result_t            r;
    int unsigned             pos;
    int unsigned             up;
    int unsigned             lc;
    int unsigned             rc;
    int unsigned             best;
    logic signed [KEY_W-1:0] tmp;
    r.status = STAT_OK;
    if (op == OP_PUSH) begin
      if (n_held >= CAPACITY) begin
        r.status = STAT_FULL;
      end else begin
        // append, then climb while the parent is strictly smaller
        heap_slots[n_held] = k;
        pos = n_held;
        n_held++;
        while (pos > 0) begin
          up = (pos - 1) / 2;
          if (heap_slots[pos] <= heap_slots[up]) break;
          tmp = heap_slots[pos];
          heap_slots[pos] = heap_slots[up];
          heap_slots[up] = tmp;
          pos = up;
        end
      end
    end else begin
      if (n_held == 0) begin
        r.status = STAT_EMPTY;
      end else begin
        // last entry to the root, then descend; left child wins a tie
        heap_slots[0] = heap_slots[n_held-1];
        n_held--;
        pos = 0;
        while (pos < n_held) begin
          lc = 2 * pos + 1;
          rc = lc + 1;
          best = pos;
          if (lc < n_held && heap_slots[lc] > heap_slots[best]) best = lc;
          if (rc < n_held && heap_slots[rc] > heap_slots[best]) best = rc;
          if (best == pos) break;
          tmp = heap_slots[pos];
          heap_slots[pos] = heap_slots[best];
          heap_slots[best] = tmp;
          pos = best;
        end
      end
    end
    r.top_key  = (n_held > 0) ? heap_slots[0] : '0;
    r.count    = COUNT_W'(n_held);
    r.is_empty = (n_held == 0);
    return r;
  endfunction

  // retire results first, then predict the newly accepted item
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_held = 0;
      result_q.delete();
      errs = 0;
      err_cnt_o <= 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (result_q.size() == 0) begin
          $error("result item with nothing expected: top_key %0d count %0d",
                 top_key_i, count_i);
          errs++;
        end else begin
          want = result_q.pop_front();
          if (top_key_i !== want.top_key) begin
            $error("top_key: expected %0d, got %0d", want.top_key, top_key_i);
            errs++;
          end
          if (count_i !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, count_i);
            errs++;
          end
          if (is_empty_i !== want.is_empty) begin
            $error("is_empty: expected %0d, got %0d", want.is_empty, is_empty_i);
            errs++;
          end
          if (status_i !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_i);
            errs++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        predicted = apply_heap_op(operation_i, key_i);
        result_q.insert(result_q.size(), predicted);
      end
      pending_o <= result_q.size();
      err_cnt_o <= errs;
    end
  end

endmodule : binary_max_heap_priority_queue_checker

### test/binary_max_heap_priority_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_max_heap_priority_queue_tb
// Drives pushes and pops into the heap queue: a directed opening over the
// extremes, ties and error cases, then random runs that fill, drain and mix,
// under shifting idle patterns and one long output stall. The checker
// instance predicts and compares; this module makes stimulus and the verdict.
// ----------------------------------------------------------------------------
module binary_max_heap_priority_queue_tb;
  import bmhpq_pkg::*;

  localparam int unsigned CAP        = CAPACITY_DEF;
  localparam int          RAND_ITEMS = 650;
  localparam int          HOLD_LEN   = 400;

  logic                    clk_i = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic                    operation = OP_PUSH;
  logic signed [KEY_W-1:0] key = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [KEY_W-1:0] top_key;
  logic [COUNT_W-1:0]      count;
  logic                    is_empty;
  logic [STAT_W-1:0]       status;

  int                      err_cnt;
  int                      pending;
  int                      send_idle_pct = 35;
  int                      recv_idle_pct = 83;
  logic                    hold_req = 1'b0;
  int unsigned             fill_lvl;

  // clock
  always #5 clk_i = ~clk_i;

  binary_max_heap_priority_queue #(
    .CAPACITY (CAP)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .operation_i (operation),
    .key_i       (key),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .top_key_o   (top_key),
    .count_o     (count),
    .is_empty_o  (is_empty),
    .status_o    (status)
  );

  binary_max_heap_priority_queue_checker #(
    .CAPACITY (CAP)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .operation_i (operation),
    .key_i       (key),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .top_key_i   (top_key),
    .count_i     (count),
    .is_empty_i  (is_empty),
    .status_i    (status),
    .err_cnt_o   (err_cnt),
    .pending_o   (pending)
  );

  // offer one item, with random gaps beforehand; returns at the accepting edge
  task automatic send_item(input logic op, input logic signed [KEY_W-1:0] k);
    logic ready_seen;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    operation <= op;
    key       <= k;
    // ready is stable mid-cycle, so sample it on the falling edge
    forever begin
      @(negedge clk_i);
      ready_seen = in_ready;
      @(posedge clk_i);
      if (ready_seen) break;
    end
    if (op == OP_PUSH && fill_lvl < CAP) fill_lvl++;
    else if (op == OP_POP && fill_lvl > 0) fill_lvl--;
  endtask

  // key mix: full range, tight cluster for ties, extremes, moderate spread
  function automatic logic signed [KEY_W-1:0] pick_key();
    logic signed [KEY_W-1:0] k;
    case ($urandom_range(3))
      0: k = $urandom;
      1: k = $signed($urandom_range(8)) - 4;
      2: case ($urandom_range(3))
           0: k = 32'sh7fff_ffff;
           1: k = 32'sh8000_0000;
           2: k = '0;
           default: k = -1;
         endcase
      default: k = $signed($urandom_range(2000)) - 1000;
    endcase
    return k;
  endfunction

  // receiver: random back-pressure, plus one long hold-off on request
  initial begin : recv_proc
    int   hold_left;
    logic hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        hold_left = HOLD_LEN;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // stimulus and verdict
  initial begin : stim_proc
    int n_sent;
    int phase;
    int pick;
    int extra;
    n_sent   = 0;
    phase    = 0;
    fill_lvl = 0;
    repeat (10) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // directed: empty pop, extremes, ties, full drain, empty pop again, push and pop
    send_item(OP_POP, 32'sh1234_5678);
    send_item(OP_PUSH, '0);
    send_item(OP_PUSH, 32'sh7fff_ffff);
    send_item(OP_PUSH, 32'sh8000_0000);
    send_item(OP_PUSH, -1);
    send_item(OP_PUSH, 5);
    send_item(OP_PUSH, 5);
    send_item(OP_PUSH, 5);
    send_item(OP_PUSH, 32'sh7fff_ffff);
    repeat (8) send_item(OP_POP, $urandom);
    send_item(OP_POP, 32'shffff_ffff);
    send_item(OP_PUSH, 32'sh8000_0000);
    send_item(OP_POP, '0);

    // random runs
    while (n_sent < RAND_ITEMS) begin
      if (phase == 0 && n_sent >= RAND_ITEMS / 3) begin
        phase = 1;
        send_idle_pct <= 83;
        recv_idle_pct <= 35;
      end else if (phase == 1 && n_sent >= 2 * RAND_ITEMS / 3) begin
        phase = 2;
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        hold_req      <= 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 40) begin
        // balanced mix
        repeat (30) begin
          send_item($urandom_range(1) ? OP_POP : OP_PUSH, pick_key());
          n_sent++;
        end
      end else if (pick < 70) begin
        // growth-biased mix
        repeat (30) begin
          send_item(($urandom_range(99) < 25) ? OP_POP : OP_PUSH, pick_key());
          n_sent++;
        end
      end else if (pick < 85) begin
        // fill to capacity, then push on full
        while (fill_lvl < CAP) begin
          send_item(OP_PUSH, pick_key());
          n_sent++;
        end
        extra = $urandom_range(3, 1);
        repeat (extra) begin
          send_item(OP_PUSH, pick_key());
          n_sent++;
        end
      end else begin
        // drain to empty, then pop on empty
        while (fill_lvl > 0) begin
          send_item(OP_POP, $urandom);
          n_sent++;
        end
        extra = $urandom_range(2, 1);
        repeat (extra) begin
          send_item(OP_POP, $urandom);
          n_sent++;
        end
      end
    end
    in_valid <= 1'b0;

    // wait for outstanding results, then idle before the verdict
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("binary_max_heap_priority_queue_tb: done, clean");
    end else begin
      $display("binary_max_heap_priority_queue_tb: done, errors");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog_proc
    #5_000_000;
    $display("binary_max_heap_priority_queue_tb: done, errors");
    $finish;
  end

endmodule : binary_max_heap_priority_queue_tb
